// File: rtl/sampd_pkg.sv
// shared types and constants for the serial adc motor pwm drive
package sampd_pkg;

  localparam int SAMPLE_BITS  = 8;
  localparam int SETUP_PHASES = 7;
  localparam int DONE_PHASE   = SETUP_PHASES + 4 * SAMPLE_BITS;
  localparam int PHASE_W      = $clog2(DONE_PHASE + 1);
  localparam int BIT_IDX_W    = $clog2(SAMPLE_BITS);
  localparam int RANGE_W      = 8;
  localparam int LOCK_W       = 20;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam logic [RANGE_W-1:0] PWM_RANGE_RESET = 8'd255;
  localparam logic [LOCK_W-1:0]  LOCKOUT_RESET   = 20'd50000;

  typedef enum logic [0:0] {
    REG_PWM_RANGE = 1'b0,
    REG_LOCKOUT   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic dio_in;
    logic button_level;
  } in_item_t;

  typedef struct packed {
    logic                   adc_select_n;
    logic                   adc_clock;
    logic                   dio_out;
    logic                   dio_drive;
    logic                   motor_a;
    logic                   motor_b;
    logic                   dir_now;
    logic [SAMPLE_BITS-1:0] speed_now;
    logic                   sample_done;
    logic                   sample_mismatch;
  } out_item_t;

  typedef struct packed {
    logic adc_select_n;
    logic adc_clock;
    logic dio_out;
    logic dio_drive;
    logic sample_done;
    logic sample_mismatch;
  } adc_pins_t;

endpackage

// File: rtl/serial_adc_motor_pwm_drive.sv
// top level: request registers, configuration port and motor drive logic
// a request accepted into the input register passes to the result register once that register is free
// throughput: one request per cycle while results are taken, as the phase, button and pwm state all step in a cycle
// the result register frees for a new request in the cycle its result is taken
// reset: synchronous active low; clears state, pwm_range to 255, lockout to 50000
module serial_adc_motor_pwm_drive import sampd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic               in_valid_r;
  in_item_t           in_data_r;
  logic               out_valid_r;
  out_item_t          out_data_r, out_data_nxt;
  logic [RANGE_W-1:0] pwm_range_r;
  logic [LOCK_W-1:0]  lockout_r;
  logic               advance;
  logic               cfg_wr;
  cfg_reg_t           cfg_sel;
  adc_pins_t          pins;
  logic [SAMPLE_BITS-1:0] speed;
  logic               direction;
  logic               pwm;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_t'(paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      REG_PWM_RANGE: prdata = APB_DATA_W'(pwm_range_r);
      REG_LOCKOUT:   prdata = APB_DATA_W'(lockout_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_range_r <= PWM_RANGE_RESET;
      lockout_r   <= LOCKOUT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PWM_RANGE: pwm_range_r <= pwdata[RANGE_W-1:0];
        REG_LOCKOUT:   lockout_r   <= pwdata[LOCK_W-1:0];
        default:       ;
      endcase
    end
  end

  assign advance  = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  sampd_adc_seq u_adc (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .dio_in (in_data_r.dio_in),
    .pins   (pins),
    .speed  (speed)
  );

  sampd_button u_button (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .button_level  (in_data_r.button_level),
    .lockout_ticks (lockout_r),
    .direction     (direction)
  );

  sampd_pwm u_pwm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .pwm_range (pwm_range_r),
    .speed     (speed),
    .pwm       (pwm)
  );

  always_comb begin
    out_data_nxt.adc_select_n    = pins.adc_select_n;
    out_data_nxt.adc_clock       = pins.adc_clock;
    out_data_nxt.dio_out         = pins.dio_out;
    out_data_nxt.dio_drive       = pins.dio_drive;
    out_data_nxt.motor_a         = pwm & ~direction;
    out_data_nxt.motor_b         = pwm & direction;
    out_data_nxt.dir_now         = direction;
    out_data_nxt.speed_now       = speed;
    out_data_nxt.sample_done     = pins.sample_done;
    out_data_nxt.sample_mismatch = pins.sample_mismatch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_mismatch_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.sample_mismatch |-> out_data_r.sample_done)
    else $error("mismatch flagged without a finished conversion");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed request produced no result");

  a_accept_fills_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> in_valid_r)
    else $error("accepted request lost from input register");

  a_one_motor_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.motor_a && out_data_r.motor_b))
    else $error("both motor lines driven");

  a_select_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.sample_done |-> out_data_r.adc_select_n)
    else $error("conversion finished with chip select low");

endmodule

// File: rtl/sampd_adc_seq.sv
// converter transaction sequencer: pin schedule, bit capture and speed choice
module sampd_adc_seq import sampd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   dio_in,
  output adc_pins_t              pins,
  output logic [SAMPLE_BITS-1:0] speed
);

  localparam logic [PHASE_W-1:0] SETUP_P     = PHASE_W'(SETUP_PHASES);
  localparam logic [PHASE_W-1:0] DONE_P      = PHASE_W'(DONE_PHASE);
  localparam logic [PHASE_W-1:0] DRIVE_END_P = PHASE_W'(6);
  localparam logic [PHASE_W-1:0] DOUT_END_P  = PHASE_W'(4);
  localparam logic [PHASE_W-1:0] MSB_END_Q   = PHASE_W'(2 * SAMPLE_BITS);
  localparam logic [PHASE_W-1:0] LSB_START_Q = PHASE_W'(2 * SAMPLE_BITS - 1);
  localparam logic [PHASE_W-1:0] BITS_P      = PHASE_W'(SAMPLE_BITS);

  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [SAMPLE_BITS-1:0] msb_r, msb_nxt;
  logic [SAMPLE_BITS-1:0] lsb_r, lsb_nxt;
  logic [SAMPLE_BITS-1:0] speed_r, speed_nxt;
  logic [PHASE_W-1:0]     p;
  logic [PHASE_W-1:0]     q;
  logic [PHASE_W-1:0]     li;

  always_comb begin
    p         = (phase_r > DONE_P) ? '0 : phase_r;
    q         = p - SETUP_P;
    li        = (q - LSB_START_Q) >> 1;
    msb_nxt   = msb_r;
    lsb_nxt   = lsb_r;
    speed_nxt = speed_r;
    pins      = '0;
    if (p < SETUP_P) begin
      if (p == '0) begin
        msb_nxt = '0;
        lsb_nxt = '0;
      end
      pins.adc_clock = p[0];
      pins.dio_drive = (p < DRIVE_END_P);
      pins.dio_out   = (p < DOUT_END_P);
    end else if (p < DONE_P) begin
      pins.adc_clock = ~q[0];
      if (q[0]) begin
        if (q < MSB_END_Q) begin
          msb_nxt = {msb_r[SAMPLE_BITS-2:0], dio_in};
        end
        if (q >= LSB_START_Q && li < BITS_P) begin
          lsb_nxt[li[BIT_IDX_W-1:0]] = lsb_r[li[BIT_IDX_W-1:0]] | dio_in;
        end
      end
    end else begin
      pins.adc_select_n = 1'b1;
      pins.sample_done  = 1'b1;
      if (msb_r == lsb_r) begin
        speed_nxt = msb_r;
      end else begin
        pins.sample_mismatch = 1'b1;
        speed_nxt = (msb_r > lsb_r) ? lsb_r : '0;
      end
    end
    phase_nxt = (p >= DONE_P) ? '0 : p + 1'b1;
  end

  assign speed = speed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      msb_r   <= '0;
      lsb_r   <= '0;
      speed_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      msb_r   <= msb_nxt;
      lsb_r   <= lsb_nxt;
      speed_r <= speed_nxt;
    end
  end

endmodule

// File: rtl/sampd_button.sv
// direction toggle with press latch and lockout counter
module sampd_button import sampd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              button_level,
  input  logic [LOCK_W-1:0] lockout_ticks,
  output logic              direction
);

  logic              dir_r, dir_nxt;
  logic              latched_r, latched_nxt;
  logic [LOCK_W-1:0] lock_r, lock_nxt;

  always_comb begin
    dir_nxt     = dir_r;
    latched_nxt = latched_r;
    lock_nxt    = lock_r;
    if (lock_r != '0) begin
      lock_nxt = lock_r - 1'b1;
    end else if (!latched_r) begin
      if (!button_level) begin
        dir_nxt     = ~dir_r;
        latched_nxt = 1'b1;
        lock_nxt    = lockout_ticks;
      end
    end else if (button_level) begin
      latched_nxt = 1'b0;
    end
  end

  assign direction = dir_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= 1'b0;
      latched_r <= 1'b0;
      lock_r    <= '0;
    end else if (step) begin
      dir_r     <= dir_nxt;
      latched_r <= latched_nxt;
      lock_r    <= lock_nxt;
    end
  end

endmodule

// File: rtl/sampd_pwm.sv
// free-running pwm counter and duty compare
module sampd_pwm import sampd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [RANGE_W-1:0]     pwm_range,
  input  logic [SAMPLE_BITS-1:0] speed,
  output logic                   pwm
);

  logic [RANGE_W-1:0] cnt_r, cnt_nxt;
  logic [RANGE_W-1:0] range;
  logic [RANGE_W-1:0] cnt;
  logic [RANGE_W:0]   cnt_inc;

  always_comb begin
    range   = (pwm_range == '0) ? RANGE_W'(1) : pwm_range;
    cnt     = (cnt_r >= range) ? '0 : cnt_r;
    pwm     = ({1'b0, cnt} < {1'b0, speed});
    cnt_inc = {1'b0, cnt} + 1'b1;
    cnt_nxt = (cnt_inc >= {1'b0, range}) ? '0 : cnt_inc[RANGE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
